// ===== hw/rtl/bcev_pkg.sv =====
// Package for the button change event generator: widths, defaults and hat decoding.
`default_nettype none

package bcev_pkg;

  localparam int unsigned RawWidth      = 32;
  localparam int unsigned HatWidth      = 10;
  localparam int unsigned PortWidth     = 3;
  localparam int unsigned IndexWidth    = 6;

  localparam int unsigned DefButtonBits = 32;
  localparam int unsigned DefUpPos      = 11;
  localparam int unsigned DefDownPos    = 12;
  localparam int unsigned DefLeftPos    = 13;
  localparam int unsigned DefRightPos   = 14;

  localparam logic signed [HatWidth-1:0] HAT_N  = 10'sd0;
  localparam logic signed [HatWidth-1:0] HAT_NE = 10'sd45;
  localparam logic signed [HatWidth-1:0] HAT_E  = 10'sd90;
  localparam logic signed [HatWidth-1:0] HAT_SE = 10'sd135;
  localparam logic signed [HatWidth-1:0] HAT_S  = 10'sd180;
  localparam logic signed [HatWidth-1:0] HAT_SW = 10'sd225;
  localparam logic signed [HatWidth-1:0] HAT_W  = 10'sd270;
  localparam logic signed [HatWidth-1:0] HAT_NW = 10'sd315;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } hat_dir_t;

  // Diagonals set two directions; anything unlisted (centered included) sets none.
  function automatic hat_dir_t decode_hat(logic signed [HatWidth-1:0] angle);
    hat_dir_t d;
    d.up    = (angle == HAT_N)  || (angle == HAT_NW) || (angle == HAT_NE);
    d.down  = (angle == HAT_S)  || (angle == HAT_SW) || (angle == HAT_SE);
    d.left  = (angle == HAT_W)  || (angle == HAT_NW) || (angle == HAT_SW);
    d.right = (angle == HAT_E)  || (angle == HAT_SE) || (angle == HAT_NE);
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/button_change_event_generator_core.sv =====
// Button change event generator: diffs each poll against the last and emits one beat per change.
// Each changed bit k is registered as an event when the scanner reaches position k (if the
// output is free). A one-bit scanner walks the changed word one position per cycle, stops
// after the last changed bit, and waits only when an event must leave while the output
// register is still stalled. New polls are stalled while it scans; a poll with no change
// never enters the scan state. Reset clears the stored button word, the port register and all valid state.
`default_nettype none

module button_change_event_generator_core
  import bcev_pkg::*;
#(
  parameter int unsigned BUTTON_BITS    = DefButtonBits,
  parameter int unsigned UP_POSITION    = DefUpPos,
  parameter int unsigned DOWN_POSITION  = DefDownPos,
  parameter int unsigned LEFT_POSITION  = DefLeftPos,
  parameter int unsigned RIGHT_POSITION = DefRightPos
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,

  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [PortWidth-1:0]       cfg_data_i,

  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  [RawWidth-1:0]        raw_buttons_i,
  input  wire  signed [HatWidth-1:0] hat_angle_i,

  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [PortWidth-1:0]       event_port_o,
  output logic [IndexWidth-1:0]      button_index_o,
  output logic                       is_pressed_o,
  output logic                       last_event_o
);

  localparam int unsigned IdxW = $clog2(BUTTON_BITS);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                 state_q;
  logic [PortWidth-1:0]   port_q;
  logic [BUTTON_BITS-1:0] prev_q;
  logic [BUTTON_BITS-1:0] shift_q;
  logic [BUTTON_BITS-1:0] press_q;
  logic [IdxW-1:0]        idx_q;

  logic                   out_valid_q;
  logic [PortWidth-1:0]   out_port_q;
  logic [IndexWidth-1:0]  out_index_q;
  logic                   out_press_q;
  logic                   out_last_q;

  hat_dir_t               dir;
  logic [BUTTON_BITS-1:0] cur_word;
  logic [BUTTON_BITS-1:0] changed;
  logic [BUTTON_BITS-1:0] shift_next;
  logic                   out_free;
  logic                   emit;

  assign dir = decode_hat(hat_angle_i);

  // Merge the hat directions into the word; positions past the word drop out.
  for (genvar i = 0; i < BUTTON_BITS; i++) begin : g_word
    assign cur_word[i] = raw_buttons_i[i]
                       | (dir.up    && (UP_POSITION    == i + 1))
                       | (dir.down  && (DOWN_POSITION  == i + 1))
                       | (dir.left  && (LEFT_POSITION  == i + 1))
                       | (dir.right && (RIGHT_POSITION == i + 1));
  end

  assign changed    = cur_word ^ prev_q;
  assign shift_next = shift_q >> 1;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (state_q == ST_SCAN) && shift_q[0] && out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      port_q      <= '0;
      prev_q      <= '0;
      shift_q     <= '0;
      press_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_port_q  <= '0;
      out_index_q <= '0;
      out_press_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        port_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            prev_q  <= cur_word;
            shift_q <= changed;
            press_q <= cur_word;
            idx_q   <= '0;
            if (changed != '0) begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Hold on a changed bit until the output register can take it.
          if (!shift_q[0] || out_free) begin
            if (shift_q[0]) begin
              out_port_q  <= port_q;
              out_index_q <= IndexWidth'(idx_q) + IndexWidth'(1);
              out_press_q <= press_q[0];
              out_last_q  <= (shift_next == '0);
            end
            shift_q <= shift_next;
            press_q <= press_q >> 1;
            idx_q   <= idx_q + IdxW'(1);
            if (shift_next == '0) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_port_o   = out_port_q;
  assign button_index_o = out_index_q;
  assign is_pressed_o   = out_press_q;
  assign last_event_o   = out_last_q;

  // The scanner is empty whenever the block takes polls.
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> shift_q == '0)
    else $error("scan word not empty while idle");

  // After a non-final event leaves, the poll still has events pending.
  a_more_events : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_event_o |=> out_valid_o || state_q == ST_SCAN)
    else $error("events lost after non-final event");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> button_index_o != '0 && button_index_o <= IndexWidth'(BUTTON_BITS))
    else $error("button index out of range");

endmodule

`default_nettype wire
